/* design/htt_pkg.sv */
// shared constants and types for the heartbeat timeout tracker
`default_nettype none
package htt_pkg;
   localparam int TableEntries = 32;
   localparam int AppCount     = 16;
   localparam int MaxResults   = 16;
   localparam int IdxW  = $clog2(TableEntries);
   localparam int CntW  = $clog2(TableEntries + 1);
   localparam int SlotW = $clog2(AppCount);
   localparam int NresW = $clog2(MaxResults + 1);

   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_PING   = 3'd1;
   localparam logic [2:0] REQ_PONG   = 3'd2;
   localparam logic [2:0] REQ_PANG   = 3'd3;
   localparam logic [2:0] REQ_FINISH = 3'd4;

   localparam logic [1:0] EV_ACTIVITY  = 2'd0;
   localparam logic [1:0] EV_NOT_FOUND = 2'd1;
   localparam logic [1:0] EV_FULL      = 2'd2;

   localparam logic [15:0] TimeoutReset = 16'd1000;

   typedef struct packed {
      logic [7:0]  method;
      logic [3:0]  app;
      logic [31:0] serial;
      logic [31:0] stamp;
   } entry_type;
endpackage
`default_nettype wire

/* design/heartbeat_timeout_tracker_top.sv */
// top level of the heartbeat timeout tracker
`default_nettype none
// Keeps an ordered table of outstanding pings and a per-application sleep
// flag. One request word is taken at a time; req_stall stays high until the
// word's work is done. A sequencer walks the table through a single
// compare/subtract path, each entry read and then checked. A pong removal
// trades its remaining scan for a shift of the tail, in which each moved
// entry is read and then written. A tick pauses each time a new result
// meets a full output register, and waits for as long as that register
// stays stalled. A finished request scans the table from the end down;
// each entry that it removes shifts every entry above it down one place.
// The entry table is a memory with one read port and one write port, read
// data registered. Results leave through one output register. A tick keeps
// its newest result hidden in that register until the next late entry turns
// up or the scan ends, so rsp_last can be set on the final result word of a
// request. The user must write csr_timeout_ms only while the block is
// idle; the block itself does not enforce it.
module heartbeat_timeout_tracker_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_req_type,
   input  wire logic [7:0]  req_method_id,
   input  wire logic [3:0]  req_app_id,
   input  wire logic [31:0] req_serial,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_kind,
   output logic [7:0]       rsp_out_method,
   output logic [3:0]       rsp_out_app,
   output logic             rsp_now_inactive,
   output logic [31:0]      rsp_duration_ms,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [15:0] csr_timeout_ms
);
   localparam int IW = htt_pkg::IdxW;
   localparam int CW = htt_pkg::CntW;
   localparam int SW = htt_pkg::SlotW;

   // sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RD    = 4'd1;  // issue read of scan index
   localparam logic [3:0] ST_CHK   = 4'd2;  // compare registered entry
   localparam logic [3:0] ST_SH_RD = 4'd3;  // read entry idx+1 for shift
   localparam logic [3:0] ST_SH_WR = 4'd4;  // write it into idx
   localparam logic [3:0] ST_DONE  = 4'd5;  // decide final result

   logic [3:0]  state_ff, state_in;
   logic [2:0]  op_ff;
   logic [7:0]  method_ff;
   logic [3:0]  app_ff;
   logic [31:0] serial_ff, now_ff;
   logic [15:0] timeout_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // scan or shift position
   logic [CW-1:0] fin_ff, fin_in;     // finished: descending scan position
   logic [htt_pkg::NresW-1:0] nres_ff, nres_in;
   logic        found_ff, found_in;
   logic        hold_ff, hold_in;     // tick result kept back until last is known

   // entry memory
   htt_pkg::entry_type mem [htt_pkg::TableEntries];
   htt_pkg::entry_type rd_ff;
   logic [IW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   htt_pkg::entry_type wr_data;

   logic                  sleep_ff [htt_pkg::AppCount];
   logic [31:0]           sstamp   [htt_pkg::AppCount];
   logic                  sl_set, sl_clr;
   logic [SW-1:0]         sl_idx;
   logic [31:0]           sl_stamp;

   // output register
   logic        ov_ff, ov_in;
   logic [1:0]  ok_ff, ok_in;
   logic [7:0]  om_ff, om_in;
   logic [3:0]  oa_ff, oa_in;
   logic        oi_ff, oi_in;
   logic [31:0] od_ff, od_in;
   logic        ol_ff, ol_in;

   logic        accept;
   logic [31:0] age;
   logic        late;
   logic [SW-1:0] ent_slot, req_slot;
   logic        match_pong, match_pang;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign age      = now_ff - rd_ff.stamp;
   assign late     = !age[31] && (age > {16'd0, timeout_ff});
   assign ent_slot = SW'(rd_ff.app % htt_pkg::AppCount);
   assign req_slot = SW'(app_ff % htt_pkg::AppCount);
   assign match_pong = rd_ff.method == method_ff && rd_ff.app == app_ff
                       && rd_ff.serial == serial_ff;
   assign match_pang = rd_ff.method == method_ff && rd_ff.app == app_ff
                       && rd_ff.serial == 32'd0;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < htt_pkg::AppCount; k++) sleep_ff[k] <= 1'b0;
      end else if (sl_set) begin
         sleep_ff[sl_idx] <= 1'b1;
      end else if (sl_clr) begin
         sleep_ff[sl_idx] <= 1'b0;
      end
      if (sl_set) sstamp[sl_idx] <= sl_stamp;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      fin_in   = fin_ff;
      nres_in  = nres_ff;
      found_in = found_ff;
      hold_in  = hold_ff;
      rd_addr  = idx_ff[IW-1:0];
      wr_en    = 1'b0;
      wr_addr  = idx_ff[IW-1:0];
      wr_data  = rd_ff;
      sl_set   = 1'b0;
      sl_clr   = 1'b0;
      sl_idx   = req_slot;
      sl_stamp = rd_ff.stamp;
      // a hidden word is not offered, so it cannot leave
      ov_in = ov_ff && (rsp_stall || hold_ff);
      ok_in = ok_ff; om_in = om_ff; oa_in = oa_ff;
      oi_in = oi_ff; od_in = od_ff; ol_in = ol_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               nres_in  = '0;
               found_in = 1'b0;
               fin_in   = count_ff;
               state_in = ST_DONE;
               priority if (req_req_type == htt_pkg::REQ_PING) begin
                  state_in = ST_DONE;
               end else if (req_req_type == htt_pkg::REQ_FINISH) begin
                  state_in = ST_RD;
               end else if (req_req_type == htt_pkg::REQ_TICK
                            || req_req_type == htt_pkg::REQ_PONG
                            || req_req_type == htt_pkg::REQ_PANG) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD: begin
            // finished scans downward from the end
            if (op_ff == htt_pkg::REQ_FINISH) begin
               if (fin_ff == '0) state_in = ST_DONE;
               else begin
                  rd_addr  = IW'(fin_ff - 1'b1);
                  idx_in   = fin_ff - 1'b1;
                  fin_in   = fin_ff - 1'b1;
                  state_in = ST_CHK;
               end
            end else if (idx_ff >= count_ff || (op_ff == htt_pkg::REQ_TICK
                         && nres_ff == htt_pkg::NresW'(htt_pkg::MaxResults))) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            unique case (op_ff)
               htt_pkg::REQ_TICK: begin
                  if (late && !sleep_ff[ent_slot]) begin
                     if (hold_ff) begin
                        // another result follows: release the held one
                        hold_in = 1'b0;
                     end else if (!ov_ff || !rsp_stall) begin
                        sl_set = 1'b1; sl_idx = ent_slot;
                        ov_in = 1'b1; ok_in = htt_pkg::EV_ACTIVITY;
                        om_in = rd_ff.method; oa_in = rd_ff.app;
                        oi_in = 1'b1; od_in = age; ol_in = 1'b0;
                        hold_in = 1'b1;
                        nres_in = nres_ff + 1'b1;
                        idx_in = idx_ff + 1'b1;
                        state_in = ST_RD;
                     end
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     state_in = ST_RD;
                  end
               end
               htt_pkg::REQ_PONG: begin
                  if (match_pong) begin
                     found_in = 1'b1;
                     state_in = ST_SH_RD;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     state_in = ST_RD;
                  end
               end
               htt_pkg::REQ_PANG: begin
                  if (match_pang) begin
                     found_in = 1'b1;
                     wr_en = 1'b1;
                     wr_data.stamp = now_ff;
                     state_in = ST_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     state_in = ST_RD;
                  end
               end
               default: begin
                  // finished request
                  if (rd_ff.app == app_ff) state_in = ST_SH_RD;
                  else state_in = ST_RD;
               end
            endcase
         end
         ST_SH_RD: begin
            if (idx_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = (op_ff == htt_pkg::REQ_FINISH) ? ST_RD : ST_DONE;
            end else begin
               rd_addr  = IW'(idx_ff + 1'b1);
               state_in = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SH_RD;
         end
         ST_DONE: begin
            if (!ov_ff || !rsp_stall || hold_ff) begin
               state_in = ST_IDLE;
               priority if ((op_ff == htt_pkg::REQ_PING
                             || (op_ff == htt_pkg::REQ_PANG && !found_ff))) begin
                  if (count_ff >= CW'(htt_pkg::TableEntries)) begin
                     ov_in = 1'b1; ok_in = htt_pkg::EV_FULL;
                     om_in = method_ff; oa_in = app_ff;
                     oi_in = 1'b0; od_in = '0; ol_in = 1'b1;
                  end else begin
                     wr_en = 1'b1; wr_addr = count_ff[IW-1:0];
                     wr_data = '{method: method_ff, app: app_ff,
                                 serial: (op_ff == htt_pkg::REQ_PING)
                                         ? serial_ff : 32'd0,
                                 stamp: now_ff};
                     count_in = count_ff + 1'b1;
                  end
               end else if (op_ff == htt_pkg::REQ_PONG) begin
                  if (!found_ff) begin
                     ov_in = 1'b1; ok_in = htt_pkg::EV_NOT_FOUND;
                     om_in = method_ff; oa_in = app_ff;
                     oi_in = 1'b0; od_in = '0; ol_in = 1'b1;
                  end else if (sleep_ff[req_slot]) begin
                     sl_clr = 1'b1;
                     ov_in = 1'b1; ok_in = htt_pkg::EV_ACTIVITY;
                     om_in = method_ff; oa_in = app_ff;
                     oi_in = 1'b0; od_in = now_ff - sstamp[req_slot];
                     ol_in = 1'b1;
                  end
               end else if (op_ff == htt_pkg::REQ_TICK && hold_ff) begin
                  // the held tick result is the final one: mark and release it
                  ol_in   = 1'b1;
                  hold_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         timeout_ff <= htt_pkg::TimeoutReset;
         ov_ff      <= 1'b0;
         hold_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
         hold_ff  <= hold_in;
         if (csr_write) timeout_ff <= csr_timeout_ms;
      end
      idx_ff <= idx_in; fin_ff <= fin_in; nres_ff <= nres_in;
      found_ff <= found_in;
      ok_ff <= ok_in; om_ff <= om_in; oa_ff <= oa_in;
      oi_ff <= oi_in; od_ff <= od_in; ol_ff <= ol_in;
      if (accept) begin
         op_ff <= req_req_type; method_ff <= req_method_id; app_ff <= req_app_id;
         serial_ff <= req_serial; now_ff <= req_now_ms;
      end
   end

   assign rsp_valid        = ov_ff && !hold_ff;
   assign rsp_event_kind   = ok_ff;
   assign rsp_out_method   = om_ff;
   assign rsp_out_app      = oa_ff;
   assign rsp_now_inactive = oi_ff;
   assign rsp_duration_ms  = od_ff;
   assign rsp_last         = ol_ff;

   // table never exceeds its size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(htt_pkg::TableEntries))
      else $error("entry count overflow");
   // no new request while busy
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("ready while busy");
   // a tick never exceeds its result limit
   assert property (@(posedge clock) disable iff (reset)
      nres_ff <= htt_pkg::NresW'(htt_pkg::MaxResults))
      else $error("too many results");
   // a held result always sits in the output register
   assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> ov_ff)
      else $error("held result lost");
endmodule
`default_nettype wire
